>>> rtl/linear_interp_resampler_unit_macros.svh
// ----------------------------------------------------------------------------
// linear_interp_resampler_unit_macros
// assertion macros for the resampler rtl (used by lirs_ctrl), empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_UNIT_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_UNIT_MACROS_SVH
`ifndef SYNTH
// checked property, disabled while reset is asserted
`define LIRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("resampler assertion failed");
// checked property, active during reset as well
`define LIRS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("resampler assertion failed");
`else
`define LIRS_ASSERT(lbl, prop)
`define LIRS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/lirs_pkg.sv
// ----------------------------------------------------------------------------
// lirs_pkg
// widths, register indexes and controller/datapath interface types
// ----------------------------------------------------------------------------
package lirs_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int MAX_RUN     = 16;

  localparam int STEP_W    = 24;
  localparam int COUNT_W   = 16;
  localparam int PHASE_W   = STEP_W + 1;
  localparam int RUN_W     = $clog2(MAX_RUN + 1);
  localparam int CFG_IDX_W = 2;
  localparam int DIFF_W    = SAMPLE_BITS + 1;
  localparam int PROD_W    = DIFF_W + FRAC_BITS + 1;

  localparam logic [PHASE_W-1:0] ONE_POS    = PHASE_W'(2 ** FRAC_BITS);
  localparam logic [STEP_W-1:0]  STEP_FLOOR =
    STEP_W'((2 ** FRAC_BITS + MAX_RUN - 1) / MAX_RUN);
  localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(2 ** FRAC_BITS);

  localparam logic [CFG_IDX_W-1:0] REG_STEP  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = CFG_IDX_W'(1);

  typedef struct packed {
    logic accept;    // capture the input word
    logic mul;       // register the interpolation product
    logic emit_pt;   // output an interpolated point
    logic phase_wb;  // store the phase left over for the next segment
    logic emit_end;  // output the end point of the vector
    logic finish;    // update the per-vector state
  } lirs_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic loop_go;
    logic tail_go;
    logic out_free;
  } lirs_status_t;

endpackage

>>> rtl/lirs_ctrl.sv
// ----------------------------------------------------------------------------
// lirs_ctrl
// sequencer: accept, multiply/emit loop per segment point, end point
// ----------------------------------------------------------------------------
`include "linear_interp_resampler_unit_macros.svh"

module lirs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  lirs_pkg::lirs_status_t status_i,
  output lirs_pkg::lirs_cmd_t    cmd_o
);
  import lirs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOP = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;
  localparam logic [1:0] S_TAIL = 2'd3;

  logic [1:0] state_d, state_q;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.have_prev ? S_LOOP : S_TAIL;
        end
      end
      S_LOOP: begin
        if (status_i.loop_go) begin
          cmd_o.mul = 1'b1;
          state_d   = S_EMIT;
        end else begin
          cmd_o.phase_wb = 1'b1;
          state_d        = S_TAIL;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_pt = 1'b1;
          state_d       = S_LOOP;
        end
      end
      S_TAIL: begin
        if (!status_i.tail_go) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.emit_end = 1'b1;
          cmd_o.finish   = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `LIRS_ASSERT(a_first_to_loop, (state_q == S_IDLE && in_valid_i && status_i.have_prev) |=> state_q == S_LOOP)
  `LIRS_ASSERT(a_emit_returns, state_q == S_EMIT |=> (state_q == S_EMIT || state_q == S_LOOP))
  `LIRS_ASSERT(a_emit_holds, (state_q == S_EMIT && !status_i.out_free) |=> state_q == S_EMIT)
  `LIRS_ASSERT(a_tail_done, state_q == S_TAIL && !(status_i.tail_go && !status_i.out_free) |=> state_q == S_IDLE)

endmodule

>>> rtl/lirs_datapath.sv
// ----------------------------------------------------------------------------
// lirs_datapath
// config registers, vector state, shared multiplier and output register
// ----------------------------------------------------------------------------
module lirs_datapath (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_valid_i,
  input  logic [lirs_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [lirs_pkg::STEP_W-1:0]              cfg_data_i,
  input  logic signed [lirs_pkg::SAMPLE_BITS-1:0]  sample_i,
  input  logic                                     last_sample_i,
  input  lirs_pkg::lirs_cmd_t                      cmd_i,
  output lirs_pkg::lirs_status_t                   status_o,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [lirs_pkg::SAMPLE_BITS-1:0]  value_o,
  output logic                                     run_end_o,
  output logic                                     vector_end_o
);
  import lirs_pkg::*;

  logic [STEP_W-1:0]            step_q;
  logic [COUNT_W-1:0]           count_q;
  logic signed [SAMPLE_BITS-1:0] prev_q, cur_q;
  logic [STEP_W-1:0]            phase_q;
  logic [COUNT_W-1:0]           done_q;
  logic                         have_q, last_q;
  logic [PHASE_W-1:0]           ph_q;
  logic [RUN_W-1:0]             n_q;
  logic signed [PROD_W-1:0]     prod_q;
  logic                         out_valid_q, run_end_q, vend_q;
  logic signed [SAMPLE_BITS-1:0] value_q;

  logic [STEP_W-1:0]            step_eff;
  logic signed [DIFF_W-1:0]     diff_s;
  logic signed [FRAC_BITS:0]    frac_s;
  logic signed [PROD_W-1:0]     prod_d;
  logic signed [PROD_W-1:0]     part_full;
  logic [SAMPLE_BITS+1:0]       interp_sum;
  logic [PHASE_W-1:0]           ph_next;
  logic [COUNT_W:0]             done_inc;
  logic [RUN_W-1:0]             n_inc;
  logic                         done_lt, inc_lt, more_pts;
  logic [PHASE_W-1:0]           ph_left;

  assign step_eff = (step_q < STEP_FLOOR) ? STEP_FLOOR : step_q;

  // shared 17x17 multiplier, frac below one while a point is due
  assign diff_s = $signed({cur_q[SAMPLE_BITS-1], cur_q})
                - $signed({prev_q[SAMPLE_BITS-1], prev_q});
  assign frac_s = $signed({1'b0, ph_q[FRAC_BITS-1:0]});
  assign prod_d = diff_s * frac_s;

  // arithmetic shift gives the floor, result stays between prev and cur
  assign part_full  = prod_q >>> FRAC_BITS;
  assign interp_sum = {{2{prev_q[SAMPLE_BITS-1]}}, prev_q} + part_full[SAMPLE_BITS+1:0];

  assign ph_next  = ph_q + {1'b0, step_eff};
  assign done_inc = {1'b0, done_q} + (COUNT_W+1)'(1);
  assign n_inc    = n_q + RUN_W'(1);
  assign done_lt  = done_q < count_q;
  assign inc_lt   = done_inc < {1'b0, count_q};
  assign ph_left  = ph_q - ONE_POS;

  // lookahead: another point from this word after the one being emitted
  assign more_pts = (ph_next < ONE_POS && inc_lt && n_inc < RUN_W'(MAX_RUN))
                 || (last_q && inc_lt);

  assign status_o.have_prev = have_q;
  assign status_o.loop_go   = (ph_q < ONE_POS) && done_lt && (n_q < RUN_W'(MAX_RUN));
  assign status_o.tail_go   = last_q && done_lt;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_RESET;
      count_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_STEP) begin
        step_q <= cfg_data_i;
      end else if (cfg_index_i == REG_COUNT) begin
        count_q <= cfg_data_i[COUNT_W-1:0];
      end
    end
  end

  // the end point always comes with finish on the last word, which clears done_q
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      phase_q <= '0;
      done_q  <= '0;
      have_q  <= 1'b0;
    end else begin
      if (cmd_i.phase_wb) begin
        phase_q <= (ph_q >= ONE_POS) ? ph_left[STEP_W-1:0] : '0;
      end
      if (cmd_i.emit_pt) begin
        done_q <= done_inc[COUNT_W-1:0];
      end
      if (cmd_i.finish) begin
        if (last_q) begin
          prev_q  <= '0;
          phase_q <= '0;
          done_q  <= '0;
          have_q  <= 1'b0;
        end else begin
          prev_q <= cur_q;
          have_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
      n_q    <= '0;
    end else if (cmd_i.accept) begin
      last_q <= last_sample_i;
      n_q    <= '0;
    end else if (cmd_i.emit_pt) begin
      n_q <= n_inc;
    end
  end

  // working word, phase walk and product
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_q <= sample_i;
      ph_q  <= {1'b0, phase_q};
    end else if (cmd_i.emit_pt) begin
      ph_q <= ph_next;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_pt || cmd_i.emit_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_pt) begin
      value_q   <= interp_sum[SAMPLE_BITS-1:0];
      run_end_q <= !more_pts;
      vend_q    <= !inc_lt;
    end else if (cmd_i.emit_end) begin
      value_q   <= cur_q;
      run_end_q <= 1'b1;
      vend_q    <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign run_end_o    = run_end_q;
  assign vector_end_o = vend_q;

endmodule

>>> rtl/linear_interp_resampler_unit.sv
// per segment point the loop state registers the product and the emit state
//   loads the output register, where it can stall; one shared multiplier
//   serves every point, and no new word is taken until the whole word and
//   any vector end point are done; a first sample of a vector skips the loop
// reset (async, active low): state cleared, step = 1.0, output_count = 0
// ----------------------------------------------------------------------------
// linear_interp_resampler_unit
// linear interpolation fractional resampler, signed samples in, points out
// ----------------------------------------------------------------------------
module linear_interp_resampler_unit (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [lirs_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [lirs_pkg::STEP_W-1:0]              cfg_data_i,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [lirs_pkg::SAMPLE_BITS-1:0]  sample_i,
  input  logic                                     last_sample_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [lirs_pkg::SAMPLE_BITS-1:0]  value_o,
  output logic                                     run_end_o,
  output logic                                     vector_end_o
);
  import lirs_pkg::*;

  lirs_cmd_t    cmd;
  lirs_status_t status;

  // register writes are taken at any time
  assign cfg_ready_o = 1'b1;

  lirs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lirs_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .sample_i      (sample_i),
    .last_sample_i (last_sample_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_o       (value_o),
    .run_end_o     (run_end_o),
    .vector_end_o  (vector_end_o)
  );

endmodule
